// ----- rtl/frc_pkg.sv -----
package frc_pkg;

  localparam int MAX_PAYLOAD_DEF = 256;
  localparam int PLEN_W = 9;
  localparam int POS_W = 10;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_SEED = 16'hFFFF;

  localparam logic [2:0] REG_HDR_PATTERN = 3'd0;
  localparam logic [2:0] REG_HDR_LEN     = 3'd1;
  localparam logic [2:0] REG_CMD_LEN     = 3'd2;
  localparam logic [2:0] REG_LF_LEN      = 3'd3;
  localparam logic [2:0] REG_CHK_LEN     = 3'd4;
  localparam logic [2:0] REG_CRC_MODE    = 3'd5;
  localparam logic [2:0] REG_LEN_MSB     = 3'd6;
  localparam logic [2:0] REG_CHK_MSB     = 3'd7;

  typedef enum logic [2:0] {
    KIND_CMD  = 3'd0,
    KIND_DATA = 3'd1,
    KIND_GOOD = 3'd2,
    KIND_BAD  = 3'd3,
    KIND_LONG = 3'd4
  } kind_t;

  // Effective (clamped) configuration and section boundaries.
  typedef struct packed {
    logic [31:0] hdr_pattern;
    logic [3:0]  h_end;
    logic [3:0]  c_end;
    logic [3:0]  n_end;
    logic [2:0]  chk_len;
    logic        crc_mode;
    logic        len_msb;
    logic        chk_msb;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] byte_value;
    logic [8:0] count;
  } res_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] byte_sel(input logic [31:0] w, input logic [1:0] idx);
    return w[{idx, 3'b000} +: 8];
  endfunction

endpackage

// ----- rtl/frc_cfg_regs.sv -----
module frc_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  output frc_pkg::cfg_t     cfg
);
  import frc_pkg::*;

  logic [31:0] hdr_pattern_r;
  logic [2:0]  hdr_len_r, cmd_len_r, lf_len_r, chk_len_r;
  logic        crc_mode_r, len_msb_r, chk_msb_r;

  function automatic logic [2:0] clamp14(input logic [2:0] v);
    return (v == 3'd0) ? 3'd1 : ((v > 3'd4) ? 3'd4 : v);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_pattern_r <= 32'h5555_5555;
      hdr_len_r     <= 3'd1;
      cmd_len_r     <= 3'd1;
      lf_len_r      <= 3'd1;
      chk_len_r     <= 3'd2;
      crc_mode_r    <= 1'b1;
      len_msb_r     <= 1'b1;
      chk_msb_r     <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_HDR_PATTERN: hdr_pattern_r <= cfg_data;
        REG_HDR_LEN:     hdr_len_r     <= clamp14(cfg_data[2:0]);
        REG_CMD_LEN:     cmd_len_r     <= (cfg_data[2:0] > 3'd4) ? 3'd4 : cfg_data[2:0];
        REG_LF_LEN:      lf_len_r      <= clamp14(cfg_data[2:0]);
        REG_CHK_LEN:     chk_len_r     <= clamp14(cfg_data[2:0]);
        REG_CRC_MODE:    crc_mode_r    <= cfg_data[0];
        REG_LEN_MSB:     len_msb_r     <= cfg_data[0];
        REG_CHK_MSB:     chk_msb_r     <= cfg_data[0];
        default:         hdr_pattern_r <= hdr_pattern_r;
      endcase
    end
  end

  logic [3:0] h_end, c_end;
  assign h_end = {1'b0, hdr_len_r};
  assign c_end = h_end + {1'b0, cmd_len_r};

  assign cfg.hdr_pattern = hdr_pattern_r;
  assign cfg.h_end       = h_end;
  assign cfg.c_end       = c_end;
  assign cfg.n_end       = c_end + {1'b0, lf_len_r};
  assign cfg.chk_len     = chk_len_r;
  assign cfg.crc_mode    = crc_mode_r;
  assign cfg.len_msb     = len_msb_r;
  assign cfg.chk_msb     = chk_msb_r;

endmodule

// ----- rtl/frc_parse.sv -----
module frc_parse #(
  parameter int MAX_PAYLOAD = frc_pkg::MAX_PAYLOAD_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  logic [7:0]     rx_byte,
  input  frc_pkg::cfg_t  cfg,
  output frc_pkg::res_t  res
);
  import frc_pkg::*;

  localparam int PAYLOAD_CAP = (MAX_PAYLOAD > 511) ? 511 : MAX_PAYLOAD;

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [PLEN_W-1:0] plen_r, plen_nxt;
  logic [31:0]       lacc_r, lacc_nxt;
  logic [15:0]       crc_r, crc_nxt;
  logic [31:0]       sum_r, sum_nxt;
  logic              mism_r, mism_nxt;

  logic [POS_W-1:0] h_end, c_end, n_end, d_end, k_end, pos, pos_inc;
  logic [15:0]      crc_base;
  logic [31:0]      sum_base, lacc_base, lacc_new, chk_val;
  logic             restart;
  logic [1:0]       lf_k, chk_i, chk_idx;
  logic [7:0]       want_hdr, want_chk;
  logic [POS_W-1:0] rel_cmd, rel_data;

  assign h_end   = POS_W'(cfg.h_end);
  assign c_end   = POS_W'(cfg.c_end);
  assign n_end   = POS_W'(cfg.n_end);
  assign d_end   = n_end + POS_W'(plen_r);
  assign k_end   = d_end + POS_W'(cfg.chk_len);
  assign pos     = (pos_r >= k_end) ? '0 : pos_r;
  assign pos_inc = pos + POS_W'(1);

  assign want_hdr = byte_sel(cfg.hdr_pattern, pos[1:0]);
  assign restart  = (pos < h_end) && ((pos == '0) || (rx_byte != want_hdr));
  assign crc_base = restart ? CRC_SEED : crc_r;
  assign sum_base = restart ? 32'd0 : sum_r;

  assign lf_k      = 2'(pos - c_end);
  assign lacc_base = (lf_k == 2'd0) ? 32'd0 : lacc_r;
  assign lacc_new  = cfg.len_msb ? {lacc_base[23:0], rx_byte}
                                 : (lacc_base | (32'(rx_byte) << {lf_k, 3'b000}));

  assign chk_i   = 2'(pos - d_end);
  assign chk_idx = cfg.chk_msb ? 2'(cfg.chk_len - 3'd1 - {1'b0, chk_i}) : chk_i;
  assign chk_val = cfg.crc_mode ? {16'h0000, crc_r} : sum_r;
  assign want_chk = byte_sel(chk_val, chk_idx);

  assign rel_cmd  = pos - h_end;
  assign rel_data = pos - n_end;

  always_comb begin
    pos_nxt  = pos;
    plen_nxt = plen_r;
    lacc_nxt = lacc_r;
    crc_nxt  = crc_r;
    sum_nxt  = sum_r;
    mism_nxt = mism_r;
    res      = '{valid: 1'b0, kind: KIND_CMD, byte_value: 8'h00, count: 9'd0};
    priority if (pos < h_end) begin
      if (rx_byte == want_hdr || rx_byte == cfg.hdr_pattern[7:0]) begin
        crc_nxt = crc16_byte(crc_base, rx_byte);
        sum_nxt = sum_base + 32'(rx_byte);
        pos_nxt = (rx_byte == want_hdr) ? pos_inc : POS_W'(1);
      end else begin
        pos_nxt = '0;
      end
    end else if (pos < c_end) begin
      crc_nxt = crc16_byte(crc_r, rx_byte);
      sum_nxt = sum_r + 32'(rx_byte);
      res     = '{valid: 1'b1, kind: KIND_CMD, byte_value: rx_byte, count: rel_cmd[8:0]};
      pos_nxt = pos_inc;
    end else if (pos < n_end) begin
      crc_nxt  = crc16_byte(crc_r, rx_byte);
      sum_nxt  = sum_r + 32'(rx_byte);
      lacc_nxt = lacc_new;
      pos_nxt  = pos_inc;
      if (pos_inc == n_end) begin
        if (lacc_new > 32'(PAYLOAD_CAP)) begin
          res = '{valid: 1'b1, kind: KIND_LONG, byte_value: 8'h00,
                  count: (lacc_new > 32'd511) ? 9'd511 : lacc_new[8:0]};
          plen_nxt = '0;
          pos_nxt  = '0;
        end else begin
          plen_nxt = lacc_new[8:0];
        end
      end
    end else if (pos < d_end) begin
      crc_nxt = crc16_byte(crc_r, rx_byte);
      sum_nxt = sum_r + 32'(rx_byte);
      res     = '{valid: 1'b1, kind: KIND_DATA, byte_value: rx_byte, count: rel_data[8:0]};
      pos_nxt = pos_inc;
    end else begin
      mism_nxt = ((chk_i == 2'd0) ? 1'b0 : mism_r) | (rx_byte != want_chk);
      pos_nxt  = pos_inc;
      if (pos_inc == k_end) begin
        res = '{valid: 1'b1, kind: (mism_nxt ? KIND_BAD : KIND_GOOD), byte_value: 8'h00,
                count: plen_r};
        pos_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      plen_r <= '0;
      lacc_r <= '0;
      crc_r  <= CRC_SEED;
      sum_r  <= '0;
      mism_r <= 1'b0;
    end else if (step) begin
      pos_r  <= pos_nxt;
      plen_r <= plen_nxt;
      lacc_r <= lacc_nxt;
      crc_r  <= crc_nxt;
      sum_r  <= sum_nxt;
      mism_r <= mism_nxt;
    end
  end

endmodule

// ----- rtl/frame_receiver_with_check_core.sv -----
// Length-prefixed frame receiver with CRC-16 or byte-sum check.
// Input channel (in_valid/in_ready/in_rx_byte): one received byte per request.
// Output channel (out_valid/out_ready/out_*): command bytes (kind 0), payload
// bytes (kind 1) and one status per frame: good (2), check failed (3) or
// too long (4). Bytes of the header, length field and check produce nothing.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes register
// cfg_index; cfg_ready is always high. Write only while no bytes are in flight.
// A byte passes the input register, then the result register, before its
// result is presented. Throughput: one byte per cycle while out_ready keeps up;
// every byte passes the header match, CRC byte update and section logic
// combinationally between the two registers.
// While a result waits with out_ready low the result register holds; the
// input register still takes one more byte, then in_ready drops until the
// result is taken.
// Reset (rst_n low, synchronous) restores register defaults, empties both
// registers and returns the parser to header hunt with the check reseeded.
module frame_receiver_with_check_core #(
  parameter int MAX_PAYLOAD = frc_pkg::MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_byte_value,
  output logic [8:0]  out_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import frc_pkg::*;

  cfg_t cfg;
  res_t res;

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       out_valid_r;
  kind_t      kind_r;
  logic [7:0] byte_r;
  logic [8:0] count_r;
  logic       step;

  assign cfg_ready = 1'b1;
  assign step      = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || step;

  frc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  frc_parse #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (in_byte_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= res.valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.valid) begin
      kind_r  <= res.kind;
      byte_r  <= res.byte_value;
      count_r <= res.count;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = kind_r;
  assign out_byte_value = byte_r;
  assign out_count      = count_r;

endmodule

// ----- dv/frame_receiver_with_check_core_test.sv -----
module frame_receiver_with_check_core_test;
  import frc_pkg::*;

  localparam int unsigned PAYLOAD_CAP = (MAX_PAYLOAD_DEF > 511) ? 511 : MAX_PAYLOAD_DEF;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned RANDOM_BYTES = 120;

  typedef enum {FR_GOOD, FR_BAD_CHECK, FR_TOO_LONG, FR_NOISE, FR_BROKEN_HDR} frame_mode_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
    logic [8:0] count;
  } frame_res_t;

  class frame_tracker;
    logic [31:0] hdr_pat;
    logic [2:0]  hdr_len, cmd_len, lf_len, chk_len;
    logic        crc_mode, len_msb, chk_msb;
    logic [9:0]  pos;
    logic [8:0]  plen;
    logic [31:0] len_acc;
    logic [15:0] crc;
    logic [31:0] sum;
    logic        mism;
    frame_res_t  due_results[$];
    int          fails;

    function new();
      hdr_pat = 32'h5555_5555;
      hdr_len = 3'd1;
      cmd_len = 3'd1;
      lf_len = 3'd1;
      chk_len = 3'd2;
      crc_mode = 1'b1;
      len_msb = 1'b1;
      chk_msb = 1'b1;
      pos = '0;
      plen = '0;
      len_acc = '0;
      crc = CRC_SEED;
      sum = '0;
      mism = 1'b0;
      fails = 0;
    endfunction

    static function int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    static function logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      r = c ^ {8'h00, b};
      repeat (8) r = r[0] ? ({1'b0, r[15:1]} ^ CRC_POLY) : {1'b0, r[15:1]};
      return r;
    endfunction

    function int unsigned hdr_bytes();
      return clip(hdr_len, 1, 4);
    endfunction

    function int unsigned cmd_bytes();
      return clip(cmd_len, 0, 4);
    endfunction

    function int unsigned lf_bytes();
      return clip(lf_len, 1, 4);
    endfunction

    function int unsigned chk_bytes();
      return clip(chk_len, 1, 4);
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        REG_HDR_PATTERN: hdr_pat = data;
        REG_HDR_LEN:     hdr_len = data[2:0];
        REG_CMD_LEN:     cmd_len = data[2:0];
        REG_LF_LEN:      lf_len = data[2:0];
        REG_CHK_LEN:     chk_len = data[2:0];
        REG_CRC_MODE:    crc_mode = data[0];
        REG_LEN_MSB:     len_msb = data[0];
        REG_CHK_MSB:     chk_msb = data[0];
        default: ;
      endcase
    endfunction

    function void fold(logic [7:0] b);
      crc = crc_next(crc, b);
      sum = sum + 32'(b);
    endfunction

    function void reseed();
      crc = CRC_SEED;
      sum = '0;
    endfunction

    function void add_result(kind_t k, logic [7:0] v, logic [8:0] c);
      frame_res_t r;
      r.kind = k;
      r.value = v;
      r.count = c;
      due_results.push_back(r);
    endfunction

    function void take_byte(logic [7:0] b);
      int unsigned h_end, c_end, n_end, k_len, d_end, k_end, p, i, sh;
      logic [31:0] chk_val;
      logic [7:0]  want;
      h_end = hdr_bytes();
      c_end = h_end + cmd_bytes();
      n_end = c_end + lf_bytes();
      k_len = chk_bytes();
      d_end = n_end + plen;
      k_end = d_end + k_len;
      p = pos;
      if (p >= k_end) p = 0;
      if (p < h_end) begin
        want = hdr_pat[8*p +: 8];
        if (b == want) begin
          if (p == 0) reseed();
          fold(b);
          p++;
        end else if (b == hdr_pat[7:0]) begin
          reseed();
          fold(b);
          p = 1;
        end else begin
          p = 0;
        end
      end else if (p < c_end) begin
        fold(b);
        add_result(KIND_CMD, b, 9'(p - h_end));
        p++;
      end else if (p < n_end) begin
        i = p - c_end;
        fold(b);
        if (i == 0) len_acc = '0;
        if (len_msb) len_acc = {len_acc[23:0], b};
        else len_acc = len_acc | (32'(b) << (8 * i));
        p++;
        if (p == n_end) begin
          if (len_acc > PAYLOAD_CAP) begin
            add_result(KIND_LONG, 8'h00, (len_acc > 32'd511) ? 9'd511 : len_acc[8:0]);
            plen = '0;
            p = 0;
          end else begin
            plen = len_acc[8:0];
          end
        end
      end else if (p < d_end) begin
        fold(b);
        add_result(KIND_DATA, b, 9'(p - n_end));
        p++;
      end else begin
        i = p - d_end;
        sh = chk_msb ? 8 * (k_len - 1 - i) : 8 * i;
        chk_val = crc_mode ? {16'h0000, crc} : sum;
        want = 8'(chk_val >> sh);
        if (i == 0) mism = 1'b0;
        if (b != want) mism = 1'b1;
        p++;
        if (p == k_end) begin
          add_result(mism ? KIND_BAD : KIND_GOOD, 8'h00, plen);
          p = 0;
        end
      end
      pos = p[9:0];
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      fails++;
    endtask

    task check_result(logic [2:0] kind, logic [7:0] value, logic [8:0] count);
      frame_res_t want;
      if (due_results.size() == 0) begin
        report($sformatf("result with none due: kind %0d byte %02h count %0d",
                         kind, value, count));
        return;
      end
      want = due_results.pop_front();
      if (kind !== want.kind)
        report($sformatf("kind %0d, want %0d", kind, want.kind));
      if (value !== want.value)
        report($sformatf("byte %02h, want %02h", value, want.value));
      if (count !== want.count)
        report($sformatf("count %0d, want %0d", count, want.count));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_kind;
  logic [7:0]  out_byte_value;
  logic [8:0]  out_count;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  frame_tracker trk;
  bit          quiet_phase = 1'b0;
  int unsigned stim_bytes = 0;

  frame_receiver_with_check_core i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_byte_value (out_byte_value),
    .out_count      (out_count),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // mostly short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned pick_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(0, 6);
    return $urandom_range(7, 40);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = (!quiet_phase && $urandom_range(0, 2) == 0) ? idle_len() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_rx_byte = b;
    do @(posedge clk); while (!in_ready);
    trk.take_byte(b);
    stim_bytes++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    trk.set_reg(idx, data);
  endtask

  // upper bits of the narrow registers carry junk on purpose
  task automatic apply_config(input logic [31:0] pat, input logic [2:0] hl, input logic [2:0] cl,
                              input logic [2:0] ll, input logic [2:0] kl, input logic cm,
                              input logic lm, input logic km);
    write_reg(REG_HDR_PATTERN, pat);
    write_reg(REG_HDR_LEN, {29'($urandom), hl});
    write_reg(REG_CMD_LEN, {29'($urandom), cl});
    write_reg(REG_LF_LEN, {29'($urandom), ll});
    write_reg(REG_CHK_LEN, {29'($urandom), kl});
    write_reg(REG_CRC_MODE, {31'($urandom), cm});
    write_reg(REG_LEN_MSB, {31'($urandom), lm});
    write_reg(REG_CHK_MSB, {31'($urandom), km});
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (trk.due_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic send_frame(input frame_mode_t mode, input int unsigned payload_len,
                            input bit fill);
    logic [7:0]  fr[$];
    logic [7:0]  b;
    logic [15:0] c;
    logic [31:0] s, chk_word, len_word;
    int unsigned h, cm, lf, k, fs, pre, bad_idx;
    h = trk.hdr_bytes();
    cm = trk.cmd_bytes();
    lf = trk.lf_bytes();
    k = trk.chk_bytes();
    if (mode == FR_NOISE) begin
      repeat ($urandom_range(1, 6)) begin
        b = 8'($urandom);
        if (b == trk.hdr_pat[7:0] && $urandom_range(0, 3) != 0) b = ~b;
        send_byte(b);
      end
      return;
    end
    if (mode == FR_BROKEN_HDR && h >= 2) begin
      pre = $urandom_range(1, h - 1);
      for (int j = 0; j < pre; j++) fr.push_back(trk.hdr_pat[8*j +: 8]);
      if ($urandom_range(0, 1) == 0) begin
        b = 8'($urandom);
        if (b == trk.hdr_pat[8*pre +: 8]) b = b + 8'd1;
        fr.push_back(b);
      end
    end
    fs = fr.size();
    for (int j = 0; j < h; j++) fr.push_back(trk.hdr_pat[8*j +: 8]);
    for (int j = 0; j < cm; j++) fr.push_back(fill ? (j[0] ? 8'hFF : 8'h00) : 8'($urandom));
    len_word = payload_len;
    if (mode == FR_TOO_LONG && lf >= 2) begin
      len_word = $urandom;
      if ($urandom_range(0, 3) == 0) len_word = 32'hFFFF_FFFF;
      if (lf < 4) len_word = len_word & ((32'h1 << (8 * lf)) - 1);
      if (len_word <= PAYLOAD_CAP) len_word = PAYLOAD_CAP + 1 + $urandom_range(0, 200);
    end
    for (int j = 0; j < lf; j++)
      fr.push_back(8'(trk.len_msb ? (len_word >> (8 * (lf - 1 - j))) : (len_word >> (8 * j))));
    if (len_word <= PAYLOAD_CAP) begin
      for (int j = 0; j < payload_len; j++)
        fr.push_back(fill ? (j[0] ? 8'hFF : 8'h00) : 8'($urandom));
      c = CRC_SEED;
      s = '0;
      for (int j = fs; j < fr.size(); j++) begin
        c = frame_tracker::crc_next(c, fr[j]);
        s = s + 32'(fr[j]);
      end
      chk_word = trk.crc_mode ? {16'h0000, c} : s;
      bad_idx = $urandom_range(0, k - 1);
      for (int j = 0; j < k; j++) begin
        b = 8'(trk.chk_msb ? (chk_word >> (8 * (k - 1 - j))) : (chk_word >> (8 * j)));
        if (mode == FR_BAD_CHECK && j == bad_idx) b = b ^ (8'h01 << $urandom_range(0, 7));
        fr.push_back(b);
      end
    end
    foreach (fr[j]) send_byte(fr[j]);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      trk.check_result(out_kind, out_byte_value, out_count);
  end

  initial begin
    int hold;
    hold = 0;
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (hold > 0) hold--;
      else if (!quiet_phase && $urandom_range(0, 7) == 0) hold = idle_len();
      out_ready = (hold == 0);
    end
  end

  initial begin
    int unsigned idle_cnt;
    idle_cnt = 0;
    while (idle_cnt < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cnt = 0;
      else
        idle_cnt++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    logic [7:0]  seq[$];
    int unsigned p, base, big_bytes, phase_start, n0, r;
    frame_mode_t mode;
    trk = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_rx_byte = 8'h00;
    cfg_valid = 1'b0;
    cfg_index = REG_HDR_PATTERN;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: all-zero/all-ones bytes, then a zero-length frame with bad check
    send_frame(FR_GOOD, 2, 1'b1);
    send_frame(FR_BAD_CHECK, 0, 1'b1);
    wait_idle();

    // two-byte header: restart on repeated first byte, then two oversize lengths
    apply_config(32'h0000_A55A, 3'd2, 3'd1, 3'd2, 3'd1, 1'b0, 1'b0, 1'b0);
    seq = '{8'h5A, 8'h5A, 8'hA5, 8'h00, 8'hFF, 8'hFF, 8'h5A, 8'hA5, 8'h3C, 8'h01, 8'h01};
    foreach (seq[j]) send_byte(seq[j]);

    base = stim_bytes;
    big_bytes = 0;
    p = 0;
    while (stim_bytes - base - big_bytes < RANDOM_BYTES) begin
      wait_idle();
      case (p)
        0: apply_config(32'h0000_0000, 3'd1, 3'd0, 3'd1, 3'd1, 1'b0, 1'b0, 1'b0);
        1: apply_config(32'hFFFF_FFFF, 3'd4, 3'd4, 3'd4, 3'd4, 1'b1, 1'b1, 1'b1);
        2: apply_config($urandom, 3'd4, 3'd0, 3'd2, 3'd4, 1'b0, 1'b1, 1'b0);
        3: apply_config($urandom, 3'd1, 3'd4, 3'd4, 3'd1, 1'b1, 1'b0, 1'b1);
        default: apply_config($urandom, 3'($urandom), 3'($urandom), 3'($urandom),
                              3'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
      endcase
      quiet_phase = (p == 5);
      if (p == 2) begin
        n0 = stim_bytes;
        send_frame(FR_GOOD, PAYLOAD_CAP, 1'b0);
        big_bytes = stim_bytes - n0;
      end
      phase_start = stim_bytes;
      while (stim_bytes - phase_start < 15) begin
        r = $urandom_range(0, 99);
        if (r < 55) mode = FR_GOOD;
        else if (r < 70) mode = FR_BAD_CHECK;
        else if (r < 80) mode = FR_TOO_LONG;
        else if (r < 90) mode = FR_NOISE;
        else mode = FR_BROKEN_HDR;
        send_frame(mode, pick_len(), 1'b0);
      end
      p++;
    end
    quiet_phase = 1'b0;
    wait_idle();

    if (trk.fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
